>>> hdl/ftf_pkg.sv
// Shared types and constants of the five-tuple first-match filter.
package ftf_pkg;

  localparam int unsigned RULE_SLOTS_DEFAULT = 128;

  localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
  localparam logic [7:0]  IP_NUM_TCP     = 8'd6;
  localparam logic [7:0]  IP_NUM_UDP     = 8'd17;

  localparam logic [1:0]  ACT_ACCEPT     = 2'd0;
  localparam logic [1:0]  ACT_DROP       = 2'd1;

  localparam logic        CMD_ADD        = 1'b0;

  typedef enum logic [1:0] {
    STATUS_ADDED      = 2'd0,
    STATUS_FULL       = 2'd1,
    STATUS_CLASSIFIED = 2'd2
  } status_e;

  typedef struct packed {
    logic [31:0] source_address;
    logic [31:0] dest_address;
    logic [15:0] source_port;
    logic [15:0] dest_port;
    logic [7:0]  ip_protocol;
  } key_t;

  typedef struct packed {
    key_t       key;
    logic [1:0] action;
  } rule_t;

  typedef struct packed {
    logic       valid;
    key_t       key;
    logic       decided;
    logic       accept;
    logic [6:0] rule_idx;
    logic [7:0] log_hits;
  } scan_t;

endpackage

>>> hdl/ftf_if.sv
// Valid/ready stream interfaces for the filter's request and result channels.
interface ftf_in_if;
  logic        valid;
  logic        ready;
  logic        cmd;
  logic [15:0] ethertype;
  logic [31:0] source_address;
  logic [31:0] dest_address;
  logic [15:0] source_port;
  logic [15:0] dest_port;
  logic [7:0]  ip_protocol;
  logic [15:0] frame_length;
  logic [1:0]  rule_action;

  modport source (
    output valid, cmd, ethertype, source_address, dest_address, source_port,
           dest_port, ip_protocol, frame_length, rule_action,
    input  ready
  );
  modport sink (
    input  valid, cmd, ethertype, source_address, dest_address, source_port,
           dest_port, ip_protocol, frame_length, rule_action,
    output ready
  );
endinterface

interface ftf_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic        accept;
  logic        rule_decided;
  logic [6:0]  deciding_rule;
  logic [7:0]  log_hits;
  logic [31:0] received_count;
  logic [31:0] accepted_count;
  logic [31:0] dropped_count;
  logic [47:0] byte_count;

  modport source (
    output valid, status, accept, rule_decided, deciding_rule, log_hits,
           received_count, accepted_count, dropped_count, byte_count,
    input  ready
  );
  modport sink (
    input  valid, status, accept, rule_decided, deciding_rule, log_hits,
           received_count, accepted_count, dropped_count, byte_count,
    output ready
  );
endinterface

>>> hdl/five_tuple_first_match_filter_top.sv
// Top level of the five-tuple first-match filter: control, counters and cell chain.
//
//   channel  direction  role      contents
//   in_i     input      sink      add-rule or classify transaction
//   out_o    output     source    status, verdict and counters, one per transaction
//
// One transaction is taken at a time. An add or a non-IPv4 classify goes straight
// to the finishing step; an IPv4 classify scans first, as the header walks the chain
// one cell a cycle. A registered result stage lets the next transaction be taken
// while a result waits; a stalled result holds only the final step of the next one.
// Reset clears the rule count, the counters and the chain's valid flags.
module five_tuple_first_match_filter_top #(
  parameter int unsigned RULE_SLOTS = ftf_pkg::RULE_SLOTS_DEFAULT
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  ftf_in_if.sink    in_i,
  ftf_out_if.source out_o
);
  import ftf_pkg::*;

  localparam int unsigned CNT_W = $clog2(RULE_SLOTS + 1);
  localparam int unsigned IDX_W = (RULE_SLOTS > 1) ? $clog2(RULE_SLOTS) : 1;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_FIN  = 2'd2;

  logic [1:0]       state_q, state_d;
  logic [CNT_W-1:0] rules_in_use_q;
  logic [31:0]      received_q, accepted_q, dropped_q;
  logic [47:0]      bytes_q;

  logic             item_cmd_q;
  logic [15:0]      item_len_q;
  rule_t            item_rule_q;
  scan_t            res_q;

  logic             out_valid_q;
  status_e          out_status_q;
  logic             out_accept_q, out_decided_q;
  logic [6:0]       out_rule_q;
  logic [7:0]       out_logs_q;
  logic [31:0]      out_rx_q, out_acc_q, out_drop_q;
  logic [47:0]      out_bytes_q;

  scan_t            chain [RULE_SLOTS+1];
  logic             in_fire, is_ipv4, is_l4, fin_fire, is_add, full, wr_en;
  logic [31:0]      rx_d, acc_d, drop_d;
  logic [47:0]      bytes_d;
  status_e          status_d;

  assign in_i.ready = (state_q == ST_IDLE);
  assign in_fire    = in_i.valid && in_i.ready;
  assign is_ipv4    = (in_i.ethertype == ETHERTYPE_IPV4);
  assign is_l4      = (in_i.ip_protocol == IP_NUM_TCP) || (in_i.ip_protocol == IP_NUM_UDP);

  always_comb begin
    chain[0].valid              = in_fire && (in_i.cmd != CMD_ADD) && is_ipv4;
    chain[0].key.source_address = in_i.source_address;
    chain[0].key.dest_address   = in_i.dest_address;
    chain[0].key.source_port    = is_l4 ? in_i.source_port : 16'd0;
    chain[0].key.dest_port      = is_l4 ? in_i.dest_port : 16'd0;
    chain[0].key.ip_protocol    = in_i.ip_protocol;
    chain[0].decided            = 1'b0;
    chain[0].accept             = 1'b1;
    chain[0].rule_idx           = 7'd0;
    chain[0].log_hits           = 8'd0;
  end

  assign fin_fire = (state_q == ST_FIN) && (!out_valid_q || out_o.ready);
  assign is_add   = (item_cmd_q == CMD_ADD);
  assign full     = (rules_in_use_q == CNT_W'(RULE_SLOTS));
  assign wr_en    = fin_fire && is_add && !full;

  genvar g;
  generate
    for (g = 0; g < RULE_SLOTS; g++) begin : g_cell
      ftf_cell #(
        .INDEX (g),
        .CNT_W (CNT_W),
        .IDX_W (IDX_W)
      ) u_cell (
        .clk_i          (clk_i),
        .rst_ni         (rst_ni),
        .rules_in_use_i (rules_in_use_q),
        .wr_en_i        (wr_en),
        .wr_idx_i       (rules_in_use_q[IDX_W-1:0]),
        .wr_rule_i      (item_rule_q),
        .scan_i         (chain[g]),
        .scan_o         (chain[g+1])
      );
    end
  endgenerate

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          state_d = ((in_i.cmd != CMD_ADD) && is_ipv4) ? ST_SCAN : ST_FIN;
        end
      end
      ST_SCAN: begin
        if (chain[RULE_SLOTS].valid) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        if (fin_fire) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    rx_d     = received_q;
    acc_d    = accepted_q;
    drop_d   = dropped_q;
    bytes_d  = bytes_q;
    status_d = full ? STATUS_FULL : STATUS_ADDED;
    if (!is_add) begin
      status_d = STATUS_CLASSIFIED;
      rx_d     = received_q + 32'd1;
      bytes_d  = bytes_q + 48'(item_len_q);
      if (res_q.accept) begin
        acc_d = accepted_q + 32'd1;
      end else begin
        drop_d = dropped_q + 32'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      rules_in_use_q <= '0;
      received_q     <= '0;
      accepted_q     <= '0;
      dropped_q      <= '0;
      bytes_q        <= '0;
      out_valid_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      if (wr_en) begin
        rules_in_use_q <= rules_in_use_q + CNT_W'(1);
      end
      if (fin_fire) begin
        received_q  <= rx_d;
        accepted_q  <= acc_d;
        dropped_q   <= drop_d;
        bytes_q     <= bytes_d;
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      item_cmd_q                      <= in_i.cmd;
      item_len_q                      <= in_i.frame_length;
      item_rule_q.key.source_address  <= in_i.source_address;
      item_rule_q.key.dest_address    <= in_i.dest_address;
      item_rule_q.key.source_port     <= in_i.source_port;
      item_rule_q.key.dest_port       <= in_i.dest_port;
      item_rule_q.key.ip_protocol     <= in_i.ip_protocol;
      item_rule_q.action              <= in_i.rule_action;
      res_q                           <= chain[0];
    end else if ((state_q == ST_SCAN) && chain[RULE_SLOTS].valid) begin
      res_q <= chain[RULE_SLOTS];
    end
    if (fin_fire) begin
      out_status_q  <= status_d;
      out_accept_q  <= !is_add && res_q.accept;
      out_decided_q <= !is_add && res_q.decided;
      out_rule_q    <= is_add ? 7'd0 : res_q.rule_idx;
      out_logs_q    <= is_add ? 8'd0 : res_q.log_hits;
      out_rx_q      <= rx_d;
      out_acc_q     <= acc_d;
      out_drop_q    <= drop_d;
      out_bytes_q   <= bytes_d;
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.status         = out_status_q;
  assign out_o.accept         = out_accept_q;
  assign out_o.rule_decided   = out_decided_q;
  assign out_o.deciding_rule  = out_rule_q;
  assign out_o.log_hits       = out_logs_q;
  assign out_o.received_count = out_rx_q;
  assign out_o.accepted_count = out_acc_q;
  assign out_o.dropped_count  = out_drop_q;
  assign out_o.byte_count     = out_bytes_q;

`ifndef SYNTHESIS
  a_tail_only_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    chain[RULE_SLOTS].valid |-> (state_q == ST_SCAN))
    else $error("Scan token left the chain outside of a scan.");

  a_count_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rules_in_use_q <= CNT_W'(RULE_SLOTS))
    else $error("Rule count exceeds the table size.");

  a_result_from_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_FIN))
    else $error("Result appeared without a finishing step.");

  a_full_no_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fin_fire && is_add && full) |=> (rules_in_use_q == CNT_W'(RULE_SLOTS)))
    else $error("Rule count changed on a full table.");
`endif

endmodule

>>> hdl/ftf_cell.sv
// One rule cell: holds one rule and updates the scan token passing through it.
module ftf_cell #(
  parameter int unsigned INDEX = 0,
  parameter int unsigned CNT_W = 8,
  parameter int unsigned IDX_W = 7
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [CNT_W-1:0]    rules_in_use_i,
  input  logic                wr_en_i,
  input  logic [IDX_W-1:0]    wr_idx_i,
  input  ftf_pkg::rule_t      wr_rule_i,
  input  ftf_pkg::scan_t      scan_i,
  output ftf_pkg::scan_t      scan_o
);
  import ftf_pkg::*;

  rule_t rule_q;
  scan_t scan_q, scan_d;
  logic  in_use;
  logic  hit;

  always_ff @(posedge clk_i) begin
    if (wr_en_i && (wr_idx_i == IDX_W'(INDEX))) begin
      rule_q <= wr_rule_i;
    end
  end

  assign in_use = rules_in_use_i > CNT_W'(INDEX);

  assign hit = in_use &&
    ((rule_q.key.source_address == '0) ||
     (rule_q.key.source_address == scan_i.key.source_address)) &&
    ((rule_q.key.dest_address == '0) ||
     (rule_q.key.dest_address == scan_i.key.dest_address)) &&
    ((rule_q.key.source_port == '0) ||
     (rule_q.key.source_port == scan_i.key.source_port)) &&
    ((rule_q.key.dest_port == '0) ||
     (rule_q.key.dest_port == scan_i.key.dest_port)) &&
    ((rule_q.key.ip_protocol == '0) ||
     (rule_q.key.ip_protocol == scan_i.key.ip_protocol));

  always_comb begin
    scan_d = scan_i;
    if (scan_i.valid && !scan_i.decided && hit) begin
      if ((rule_q.action == ACT_ACCEPT) || (rule_q.action == ACT_DROP)) begin
        scan_d.decided  = 1'b1;
        scan_d.accept   = (rule_q.action == ACT_ACCEPT);
        scan_d.rule_idx = 7'(INDEX);
      end else if (scan_i.log_hits != 8'hFF) begin
        scan_d.log_hits = scan_i.log_hits + 8'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_q <= '0;
    end else begin
      scan_q <= scan_d;
    end
  end

  assign scan_o = scan_q;

endmodule
